### rtl/core/frls_pkg.sv
// Shared types and constants of the flash record log store.
package frls_pkg;

    localparam int SLOT_COUNT       = 64;
    localparam int WORDS_PER_RECORD = 6;
    localparam int FIELD_COUNT      = 6;
    localparam int REGION_WORDS     = SLOT_COUNT * WORDS_PER_RECORD;
    localparam int WORD_W           = 32;
    localparam int ADDR_W           = $clog2(REGION_WORDS);
    localparam int SLOT_W           = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FREE_W           = $clog2(SLOT_COUNT + 1);
    localparam int IDX_W            = $clog2(FIELD_COUNT);
    localparam int SLOT_OUT_W       = 7;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [WORD_W-1:0] ERASED_WORD  = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] DEFAULT_TIME = 32'd100;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SAVE = 1'b1;

    localparam logic [PADDR_W-3:0] REG_STORE_ENABLE = '0;

    typedef struct packed {
        logic              operation;
        logic [WORD_W-1:0] pulse_width;
        logic [WORD_W-1:0] pause_length;
        logic [WORD_W-1:0] repeat_count;
        logic [WORD_W-1:0] pulse_unit;
        logic [WORD_W-1:0] pause_unit;
        logic [WORD_W-1:0] count_unit;
    } cmd_t;

    typedef struct packed {
        logic                  performed;
        logic [WORD_W-1:0]     out_pulse_width;
        logic [WORD_W-1:0]     out_pause_length;
        logic [WORD_W-1:0]     out_repeat_count;
        logic [WORD_W-1:0]     out_pulse_unit;
        logic [WORD_W-1:0]     out_pause_unit;
        logic [WORD_W-1:0]     out_count_unit;
        logic                  record_found;
        logic [SLOT_OUT_W-1:0] slot_used;
        logic                  region_erased;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_FINISH
    } state_t;

endpackage

### rtl/core/frls_ram.sv
// Generic single-port RAM with registered read.
module frls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/core/flash_record_log_store.sv
// Top level of the flash record log store: sequencer, register and record memory.
//
// Usage:
//   Command channel: an item (cmd) is taken at a clock edge where start is high
//   and busy is low. cmd.operation selects load of the latest record or save of
//   the six given words.
//   Result channel: done is high for one cycle with result; it cannot be held off.
//   APB port: store_enable at byte address 0, bit 0. Write only while idle.
//   Sequence: straight to the finish state when disabled or loading from an empty
//   region; otherwise a memory read state and a write state per record word, in
//   turn through the single memory port. One item at a time: busy stays high until the
//   cycle in which done is shown.
//   A first-free-slot pointer and a flag for a free slot with stale words stand
//   in for the head scan and make the region erase immediate: no sweep needed.
//   Reset: region reads as erased, store_enable is 1, no clearing pass.
module flash_record_log_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [frls_pkg::PADDR_W-1:0] paddr,
    input  logic [frls_pkg::PDATA_W-1:0] pwdata,
    output logic [frls_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         start,
    input  frls_pkg::cmd_t               cmd,
    output logic                         busy,
    output logic                         done,
    output frls_pkg::result_t            result
);

    import frls_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic                enable_reg;
    logic [FREE_W-1:0]   free_reg;
    logic                dirty_reg;
    logic                op_reg;
    logic                perf_reg;
    logic                found_reg;
    logic                erase_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [WORD_W-1:0]   words_reg [FIELD_COUNT];
    logic                done_reg;
    result_t             result_reg;

    logic                accept;
    logic                cfg_wr;
    logic                full;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   old_word;
    logic                last_idx;
    result_t             result_next;

    frls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (REGION_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign accept   = start && !busy;
    assign cfg_wr   = psel && penable && pwrite;
    assign full     = (free_reg == FREE_W'(SLOT_COUNT));
    assign last_idx = (idx_reg == IDX_W'(FIELD_COUNT - 1));
    assign old_word = (dirty_reg && !erase_reg) ? ram_rdata : ERASED_WORD;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!enable_reg || (cmd.operation == OP_LOAD && free_reg == '0))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:   state_next = ST_WRITE;
            ST_WRITE:  state_next = last_idx ? ST_FINISH : ST_READ;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        ram_we    = (state_reg == ST_WRITE) && (op_reg == OP_SAVE);
        ram_addr  = ADDR_W'(slot_reg * WORDS_PER_RECORD) + ADDR_W'(idx_reg);
        ram_wdata = words_reg[idx_reg] & old_word;
    end

    always_comb
    begin
        result_next = '0;
        if (perf_reg)
        begin
            result_next.performed = 1'b1;
            result_next.slot_used = SLOT_OUT_W'(slot_reg);
            if (op_reg == OP_SAVE)
            begin
                result_next.region_erased = erase_reg;
            end
            else if (found_reg)
            begin
                result_next.record_found     = 1'b1;
                result_next.out_pulse_width  = words_reg[0];
                result_next.out_pause_length = words_reg[1];
                result_next.out_repeat_count = words_reg[2];
                result_next.out_pulse_unit   = words_reg[3];
                result_next.out_pause_unit   = words_reg[4];
                result_next.out_count_unit   = words_reg[5];
            end
            else
            begin
                result_next.out_pulse_width  = DEFAULT_TIME;
                result_next.out_pause_length = DEFAULT_TIME;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            enable_reg <= 1'b1;
            free_reg   <= '0;
            dirty_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FINISH);
            if (cfg_wr && paddr[PADDR_W-1:2] == REG_STORE_ENABLE)
            begin
                enable_reg <= pwdata[0];
            end
            if (state_reg == ST_FINISH && perf_reg && op_reg == OP_SAVE)
            begin
                if (words_reg[0] != ERASED_WORD)
                begin
                    free_reg  <= FREE_W'(slot_reg) + FREE_W'(1);
                    dirty_reg <= 1'b0;
                end
                else
                begin
                    free_reg  <= FREE_W'(slot_reg);
                    dirty_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= cmd.operation;
            perf_reg     <= enable_reg;
            erase_reg    <= (cmd.operation == OP_SAVE) && full;
            found_reg    <= (cmd.operation == OP_LOAD) && (free_reg != '0);
            idx_reg      <= '0;
            words_reg[0] <= cmd.pulse_width;
            words_reg[1] <= cmd.pause_length;
            words_reg[2] <= cmd.repeat_count;
            words_reg[3] <= cmd.pulse_unit;
            words_reg[4] <= cmd.pause_unit;
            words_reg[5] <= cmd.count_unit;
            if (cmd.operation == OP_LOAD)
            begin
                slot_reg <= (free_reg != '0) ? SLOT_W'(free_reg - FREE_W'(1)) : '0;
            end
            else
            begin
                slot_reg <= full ? '0 : SLOT_W'(free_reg);
            end
        end
        else if (state_reg == ST_WRITE)
        begin
            words_reg[idx_reg] <= (op_reg == OP_LOAD) ? ram_rdata : ram_wdata;
            if (!last_idx)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
        if (state_reg == ST_FINISH)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_STORE_ENABLE) ?
                    {{(PDATA_W-1){1'b0}}, enable_reg} : '0;

endmodule

### rtl/core/frls_checker.sv
// Port-level checks of the flash record log store and their binding.
module frls_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input frls_pkg::result_t result
);

    import frls_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an item in progress");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("one item gave two results");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.performed |->
            result.slot_used == '0 && !result.record_found && !result.region_erased)
        else $error("disabled result carries data");

    a_erase_slot0: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.region_erased |-> result.slot_used == '0 && !result.record_found)
        else $error("erase did not write slot 0");

endmodule

bind flash_record_log_store frls_checker u_frls_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### bench/tb_flash_record_log_store.sv
// Self-checking testbench of the flash record log store against a shadow log.
`timescale 1ns / 1ps

module tb_flash_record_log_store;

    import frls_pkg::*;

    localparam int                 STALL_LIMIT = 2000;
    localparam int                 SETTLE      = 20;
    localparam logic [PADDR_W-1:0] ADDR_ENABLE = {REG_STORE_ENABLE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE  = {~REG_STORE_ENABLE, 2'b00};

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               start   = 1'b0;
    cmd_t               cmd     = '0;
    logic               busy;
    logic               done;
    result_t            result;

    cmd_t              pending_cmds[$];
    result_t           due_results[$];
    logic [WORD_W-1:0] shadow_flash[REGION_WORDS];
    logic              shadow_enable;
    bit                gaps_on     = 1'b1;
    int                gap_left    = 0;
    int                fault_count = 0;
    int                stall_count = 0;

    flash_record_log_store dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #4 clk = ~clk;

    function automatic int first_free_slot();
        int s;
        s = 0;
        while (s < SLOT_COUNT && shadow_flash[s * WORDS_PER_RECORD] != ERASED_WORD)
            s++;
        return s;
    endfunction

    function automatic result_t apply_command(input cmd_t c);
        result_t           r;
        int                slot;
        int                base;
        logic [WORD_W-1:0] w[FIELD_COUNT];
        r = '0;
        if (!shadow_enable)
            return r;
        w[0] = c.pulse_width;
        w[1] = c.pause_length;
        w[2] = c.repeat_count;
        w[3] = c.pulse_unit;
        w[4] = c.pause_unit;
        w[5] = c.count_unit;
        slot = first_free_slot();
        r.performed = 1'b1;
        if (c.operation == OP_LOAD)
        begin
            if (slot == 0)
            begin
                r.out_pulse_width  = DEFAULT_TIME;
                r.out_pause_length = DEFAULT_TIME;
            end
            else
            begin
                base = (slot - 1) * WORDS_PER_RECORD;
                r.out_pulse_width  = shadow_flash[base];
                r.out_pause_length = shadow_flash[base + 1];
                r.out_repeat_count = shadow_flash[base + 2];
                r.out_pulse_unit   = shadow_flash[base + 3];
                r.out_pause_unit   = shadow_flash[base + 4];
                r.out_count_unit   = shadow_flash[base + 5];
                r.record_found     = 1'b1;
                r.slot_used        = SLOT_OUT_W'(slot - 1);
            end
        end
        else
        begin
            if (slot >= SLOT_COUNT)
            begin
                foreach (shadow_flash[i])
                    shadow_flash[i] = ERASED_WORD;
                slot = 0;
                r.region_erased = 1'b1;
            end
            base = slot * WORDS_PER_RECORD;
            for (int j = 0; j < FIELD_COUNT; j++)
                shadow_flash[base + j] &= w[j];
            r.slot_used = SLOT_OUT_W'(slot);
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ERASED_WORD;
            default: return $urandom();
        endcase
    endfunction

    function automatic cmd_t random_cmd(input logic op);
        cmd_t c;
        c.operation    = op;
        c.pulse_width  = pick_word();
        c.pause_length = pick_word();
        c.repeat_count = pick_word();
        c.pulse_unit   = pick_word();
        c.pause_unit   = pick_word();
        c.count_unit   = pick_word();
        return c;
    endfunction

    function automatic cmd_t cmd_of(input logic op, input logic [WORD_W-1:0] w0,
                                     input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
                                     input logic [WORD_W-1:0] w3, input logic [WORD_W-1:0] w4,
                                     input logic [WORD_W-1:0] w5);
        cmd_t c;
        c.operation    = op;
        c.pulse_width  = w0;
        c.pause_length = w1;
        c.repeat_count = w2;
        c.pulse_unit   = w3;
        c.pause_unit   = w4;
        c.count_unit   = w5;
        return c;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fault_count++;
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || due_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        wait_idle();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ENABLE)
            shadow_enable = data[0];
    endtask

    task automatic set_enable(input logic en);
        logic [PDATA_W-1:0] data;
        data    = $urandom();
        data[0] = en;
        write_reg(ADDR_ENABLE, data);
    endtask

    // fill the log to the last slot, read it back full, then force the erase
    task automatic fill_and_wrap();
        int   need;
        cmd_t c;
        wait_idle();
        need = SLOT_COUNT - first_free_slot();
        repeat (need)
        begin
            c = random_cmd(OP_SAVE);
            if (c.pulse_width == ERASED_WORD)
                c.pulse_width = '0;
            pending_cmds.push_back(c);
        end
        pending_cmds.push_back(random_cmd(OP_LOAD));
        pending_cmds.push_back(random_cmd(OP_SAVE));
        pending_cmds.push_back(random_cmd(OP_LOAD));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            cmd      <= '0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                due_results.push_back(apply_command(pending_cmds.pop_front()));
                if (gaps_on && $urandom_range(0, 2) == 0)
                    gap_left = $urandom_range(1, 14);
            end
            if (start && busy)
            begin
                // hold the item until taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                start <= 1'b1;
                cmd   <= pending_cmds[0];
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: %p", result);
                fault_count++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("performed", WORD_W'(want.performed),
                            WORD_W'(result.performed));
                check_field("out_pulse_width", want.out_pulse_width, result.out_pulse_width);
                check_field("out_pause_length", want.out_pause_length, result.out_pause_length);
                check_field("out_repeat_count", want.out_repeat_count, result.out_repeat_count);
                check_field("out_pulse_unit", want.out_pulse_unit, result.out_pulse_unit);
                check_field("out_pause_unit", want.out_pause_unit, result.out_pause_unit);
                check_field("out_count_unit", want.out_count_unit, result.out_count_unit);
                check_field("record_found", WORD_W'(want.record_found),
                            WORD_W'(result.record_found));
                check_field("slot_used", WORD_W'(want.slot_used),
                            WORD_W'(result.slot_used));
                check_field("region_erased", WORD_W'(want.region_erased),
                            WORD_W'(result.region_erased));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("** flash_record_log_store: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        foreach (shadow_flash[i])
            shadow_flash[i] = ERASED_WORD;
        shadow_enable = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty log, an all-ones head that leaves its slot free, AND programming
        pending_cmds.push_back(cmd_of(OP_LOAD, '0, '0, '0, '0, '0, '0));
        pending_cmds.push_back(cmd_of(OP_SAVE, ERASED_WORD, 32'h1234_5678, 32'hFFFF_0000,
                                      32'h0F0F_0F0F, 32'h8000_0001, ERASED_WORD));
        pending_cmds.push_back(cmd_of(OP_LOAD, ERASED_WORD, ERASED_WORD, ERASED_WORD,
                                      ERASED_WORD, ERASED_WORD, ERASED_WORD));
        pending_cmds.push_back(cmd_of(OP_SAVE, ERASED_WORD, '0, ERASED_WORD, '0,
                                      ERASED_WORD, '0));
        pending_cmds.push_back(cmd_of(OP_SAVE, '0, ERASED_WORD, ERASED_WORD, ERASED_WORD,
                                      32'h7FFF_FFFF, 32'hFFFF_FFFE));
        pending_cmds.push_back(cmd_of(OP_LOAD, '0, '0, '0, '0, '0, '0));
        pending_cmds.push_back(cmd_of(OP_SAVE, 32'hFFFF_FFFE, ERASED_WORD, ERASED_WORD,
                                      ERASED_WORD, ERASED_WORD, ERASED_WORD));
        pending_cmds.push_back(cmd_of(OP_SAVE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                      32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        pending_cmds.push_back(cmd_of(OP_SAVE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        pending_cmds.push_back(cmd_of(OP_LOAD, 32'hDEAD_BEEF, 32'h1, 32'h2, 32'h3, 32'h4,
                                      32'h5));
        pending_cmds.push_back(cmd_of(OP_SAVE, 32'h0000_0001, 32'h8000_0000, 32'd100,
                                      32'd100, 32'd0, 32'hFFFF_FFFF));
        pending_cmds.push_back(cmd_of(OP_LOAD, '0, '0, '0, '0, '0, '0));

        // disabled block, upper data bits and a write to an unused address
        write_reg(ADDR_ENABLE, 32'hFFFF_FFFE);
        pending_cmds.push_back(random_cmd(OP_LOAD));
        pending_cmds.push_back(cmd_of(OP_SAVE, '0, '0, '0, '0, '0, '0));
        write_reg(ADDR_SPARE, 32'h0000_0001);
        pending_cmds.push_back(random_cmd(OP_LOAD));
        write_reg(ADDR_ENABLE, 32'h8000_0001);
        pending_cmds.push_back(random_cmd(OP_LOAD));

        fill_and_wrap();

        for (int p = 0; p < 4; p++)
        begin
            set_enable(p != 1);
            repeat (60)
                pending_cmds.push_back(random_cmd($urandom_range(0, 99) < 65 ? OP_SAVE : OP_LOAD));
        end

        set_enable(1'b1);
        wait_idle();
        gaps_on = 1'b0;
        fill_and_wrap();
        repeat (10)
            pending_cmds.push_back(random_cmd($urandom_range(0, 1) ? OP_SAVE : OP_LOAD));

        wait_idle();
        if (fault_count == 0)
            $display("** flash_record_log_store: PASSED **");
        else
            $display("** flash_record_log_store: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/core/frls_pkg.sv
rtl/core/frls_ram.sv
rtl/core/flash_record_log_store.sv
rtl/core/frls_checker.sv
bench/tb_flash_record_log_store.sv
